FILE: hdl/float_matrix_multiply_unit_defines.svh
// assertion macros for the float matrix multiply unit
`ifndef FLOAT_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define FLOAT_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`ifndef SYNTH
// property checked on every clock edge outside reset
`define FMM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fmm assertion failed");
// property checked on every clock edge, reset included
`define FMM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fmm assertion failed");
`else
`define FMM_ASSERT(label, prop)
`define FMM_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: hdl/fmm_pkg.sv
`default_nettype none
package fmm_pkg;

  localparam int DEF_MAX_ROWS   = 128;
  localparam int DEF_MAX_COLS   = 128;
  localparam int DEF_MAX_DEPTH  = 128;
  localparam int DEF_DEPTH_TILE = 64;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [31:0] ONE32  = 32'h3F80_0000;
  localparam logic [7:0]  SIZE_RESET = 8'd128;

  typedef enum logic [1:0] {
    REQ_WRITE_A = 2'd0,
    REQ_WRITE_B = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_DEPTH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  row_index;
    logic [6:0]  col_index;
    logic [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] c_value;
    logic [6:0]  out_row;
    logic [6:0]  out_col;
    logic        range_error;
  } out_item_t;

  // handshake between sequencer and the shared fma unit
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } fma_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fma_rsp_t;

  // index of highest set bit, zero for zero input
  function automatic logic [5:0] top_bit64(input logic [63:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/float_matrix_multiply_unit.sv
// channel   ports                          accepted when
// ------    -----------------------------  ------------------------------
// input     in_valid in_ready in_data      in_valid && in_ready
// result    out_valid out_ready out_data   out_valid && out_ready
// config    cfg_we cfg_index cfg_data      cfg_we high at clock edge
//
// a write beat is stored as it is accepted; a compute beat is accepted, then walks
// each depth entry with a store read, an fma issue and the six fma stages, merges
// each finished depth tile into the result through the same fma, and ends with the
// hand-over of the result to the output register
// reset is synchronous, active low; stores are not cleared and need writing first
// no new beat is taken while a compute is in flight; a finished result waits in
// the output register and write beats are still taken meanwhile
`default_nettype none
`include "float_matrix_multiply_unit_defines.svh"
module float_matrix_multiply_unit #(
  parameter int MAX_ROWS   = fmm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = fmm_pkg::DEF_MAX_COLS,
  parameter int MAX_DEPTH  = fmm_pkg::DEF_MAX_DEPTH,
  parameter int DEPTH_TILE = fmm_pkg::DEF_DEPTH_TILE
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fmm_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fmm_pkg::out_item_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [7:0]        cfg_data
);

  localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
  localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
  localparam int AW      = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int BW      = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int TW      = $clog2(DEPTH_TILE + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC_GO,
    ST_MAC_WAIT,
    ST_ADD_GO,
    ST_ADD_WAIT,
    ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [7:0]         rows_r, cols_r, depth_r;
  logic [6:0]         row_r, col_r;
  logic [7:0]         k_r, k_nxt, nd_r, nd_nxt;
  logic [TW-1:0]      tcnt_r, tcnt_nxt, tcnt_inc;
  logic [31:0]        tile_r, tile_nxt, acc_r, acc_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  fmm_pkg::out_item_t out_data_r, out_data_nxt;
  logic [6:0]         row_nxt, col_nxt;

  // effective sizes, register values clipped to the build maximum
  logic [7:0] nr, nc, nd;
  assign nr = (11'(rows_r)  > 11'(MAX_ROWS))  ? 8'(MAX_ROWS)  : rows_r;
  assign nc = (11'(cols_r)  > 11'(MAX_COLS))  ? 8'(MAX_COLS)  : cols_r;
  assign nd = (11'(depth_r) > 11'(MAX_DEPTH)) ? 8'(MAX_DEPTH) : depth_r;

  logic in_fire;
  logic row_in_nr, col_in_nc, row_in_nd, col_in_nd;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign row_in_nr = {1'b0, in_data.row_index} < nr;
  assign col_in_nc = {1'b0, in_data.col_index} < nc;
  assign row_in_nd = {1'b0, in_data.row_index} < nd;
  assign col_in_nd = {1'b0, in_data.col_index} < nd;

  // store write side
  logic          a_we, b_we;
  logic [31:0]   a_wsum, b_wsum, a_rsum, b_rsum;
  logic [AW-1:0] a_waddr, a_raddr;
  logic [BW-1:0] b_waddr, b_raddr;
  logic          rd_en;
  logic [31:0]   a_rdata, b_rdata;

  assign a_we    = in_fire && (in_data.req_type == fmm_pkg::REQ_WRITE_A) &&
                   row_in_nr && col_in_nd;
  assign b_we    = in_fire && (in_data.req_type == fmm_pkg::REQ_WRITE_B) &&
                   row_in_nd && col_in_nc;
  assign a_wsum  = 32'(in_data.row_index) * 32'(MAX_DEPTH) + 32'(in_data.col_index);
  assign b_wsum  = 32'(in_data.row_index) * 32'(MAX_COLS)  + 32'(in_data.col_index);
  assign a_waddr = a_wsum[AW-1:0];
  assign b_waddr = b_wsum[BW-1:0];

  // read side walks k along row of A and column of B
  assign rd_en   = (state_r == ST_READ);
  assign a_rsum  = 32'(row_r) * 32'(MAX_DEPTH) + 32'(k_r);
  assign b_rsum  = 32'(k_r) * 32'(MAX_COLS) + 32'(col_r);
  assign a_raddr = a_rsum[AW-1:0];
  assign b_raddr = b_rsum[BW-1:0];

  fmm_mats #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_mats (
    .clk     (clk),
    .a_we    (a_we),
    .a_waddr (a_waddr),
    .b_we    (b_we),
    .b_waddr (b_waddr),
    .wdata   (in_data.elem_value),
    .rd_en   (rd_en),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata)
  );

  // shared fused multiply-add: depth steps and tile merges both go through it
  fmm_pkg::fma_req_t fma_req;
  fmm_pkg::fma_rsp_t fma_rsp;

  always_comb begin
    fma_req.start = 1'b0;
    fma_req.a     = a_rdata;
    fma_req.b     = b_rdata;
    fma_req.c     = tile_r;
    if (state_r == ST_MAC_GO) begin
      fma_req.start = 1'b1;
    end else if (state_r == ST_ADD_GO) begin
      // acc + tile * 1.0, rounded once
      fma_req.start = 1'b1;
      fma_req.a     = tile_r;
      fma_req.b     = fmm_pkg::ONE32;
      fma_req.c     = acc_r;
    end
  end

  fmm_fma u_fma (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fma_req),
    .rsp   (fma_rsp)
  );

  assign tcnt_inc = tcnt_r + 1'b1;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    nd_nxt        = nd_r;
    tcnt_nxt      = tcnt_r;
    tile_nxt      = tile_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.req_type == fmm_pkg::REQ_COMPUTE)) begin
          row_nxt  = in_data.row_index;
          col_nxt  = in_data.col_index;
          k_nxt    = 8'd0;
          nd_nxt   = nd;
          tcnt_nxt = '0;
          tile_nxt = 32'd0;
          acc_nxt  = 32'd0;
          err_nxt  = !(row_in_nr && col_in_nc);
          // range error or zero depth: result is +0 straight away
          state_nxt = (!(row_in_nr && col_in_nc) || (nd == 8'd0)) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MAC_GO;
      end
      ST_MAC_GO: begin
        state_nxt = ST_MAC_WAIT;
      end
      ST_MAC_WAIT: begin
        if (fma_rsp.done) begin
          tile_nxt = fma_rsp.result;
          k_nxt    = k_r + 8'd1;
          tcnt_nxt = tcnt_inc;
          // tile closes at the tile length or at the last depth entry
          if (((k_r + 8'd1) == nd_r) || (tcnt_inc == TW'(DEPTH_TILE))) begin
            state_nxt = ST_ADD_GO;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_ADD_GO: begin
        state_nxt = ST_ADD_WAIT;
      end
      ST_ADD_WAIT: begin
        if (fma_rsp.done) begin
          acc_nxt  = fma_rsp.result;
          tile_nxt = 32'd0;
          tcnt_nxt = '0;
          state_nxt = (k_r == nd_r) ? ST_DONE : ST_READ;
        end
      end
      ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.c_value     = err_r ? 32'd0 : acc_r;
          out_data_nxt.out_row     = row_r;
          out_data_nxt.out_col     = col_r;
          out_data_nxt.range_error = err_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rows_r      <= fmm_pkg::SIZE_RESET;
      cols_r      <= fmm_pkg::SIZE_RESET;
      depth_r     <= fmm_pkg::SIZE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          fmm_pkg::CFG_ROWS:  rows_r  <= cfg_data;
          fmm_pkg::CFG_COLS:  cols_r  <= cfg_data;
          fmm_pkg::CFG_DEPTH: depth_r <= cfg_data;
          default: ;
        endcase
      end
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    nd_r       <= nd_nxt;
    tcnt_r     <= tcnt_nxt;
    tile_r     <= tile_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // range error always carries a zero value
  `FMM_ASSERT(a_err_zero, out_valid && out_data.range_error |-> out_data.c_value == 32'd0)
  // depth walk never reads past the configured depth
  `FMM_ASSERT(a_k_bound, (state_r == ST_READ || state_r == ST_MAC_GO) |-> k_r < nd_r)
  // fma results only arrive while the sequencer waits for them
  `FMM_ASSERT(a_fma_done, fma_rsp.done |-> (state_r == ST_MAC_WAIT || state_r == ST_ADD_WAIT))
  // a compute beat never starts while busy
  `FMM_ASSERT_ALWAYS(a_no_take_busy, (rst_n && state_r != ST_IDLE) |-> !in_ready)

endmodule
`default_nettype wire

FILE: hdl/fmm_fma.sv
`default_nettype none
// six-stage fused multiply-add, binary32, round to nearest even
module fmm_fma (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fmm_pkg::fma_req_t req,
  output fmm_pkg::fma_rsp_t      rsp
);

  // stage 1 decode
  logic       sa, sb, sc, sp;
  logic [7:0] ea, eb, ec;
  logic [22:0] fa, fb, fc;
  logic       az, bz, cz, nan_any;
  logic       spec;
  logic [31:0] sval;
  logic [23:0] ma, mb, mc;
  logic [7:0] eea, eeb, eec;

  assign sa = req.a[31];
  assign sb = req.b[31];
  assign sc = req.c[31];
  assign sp = sa ^ sb;
  assign ea = req.a[30:23];
  assign eb = req.b[30:23];
  assign ec = req.c[30:23];
  assign fa = req.a[22:0];
  assign fb = req.b[22:0];
  assign fc = req.c[22:0];
  assign az = (ea == 8'd0) && (fa == 23'd0);
  assign bz = (eb == 8'd0) && (fb == 23'd0);
  assign cz = (ec == 8'd0) && (fc == 23'd0);
  assign nan_any = ((ea == 8'hFF) && (fa != 23'd0)) || ((eb == 8'hFF) && (fb != 23'd0)) ||
                   ((ec == 8'hFF) && (fc != 23'd0));
  assign ma  = (ea != 8'd0) ? {1'b1, fa} : {1'b0, fa};
  assign mb  = (eb != 8'd0) ? {1'b1, fb} : {1'b0, fb};
  assign mc  = (ec != 8'd0) ? {1'b1, fc} : {1'b0, fc};
  assign eea = (ea != 8'd0) ? ea : 8'd1;
  assign eeb = (eb != 8'd0) ? eb : 8'd1;
  assign eec = (ec != 8'd0) ? ec : 8'd1;

  always_comb begin
    spec = 1'b1;
    sval = 32'd0;
    if (nan_any) begin
      sval = fmm_pkg::QNAN32;
    end else if ((ea == 8'hFF) || (eb == 8'hFF)) begin
      if (az || bz) begin
        sval = fmm_pkg::QNAN32;
      end else if ((ec == 8'hFF) && (sc != sp)) begin
        sval = fmm_pkg::QNAN32;
      end else begin
        sval = {sp, 8'hFF, 23'd0};
      end
    end else if (ec == 8'hFF) begin
      sval = req.c;
    end else if (az || bz) begin
      if (cz) sval = (sp == sc) ? {sp, 31'd0} : 32'd0;
      else    sval = req.c;
    end else begin
      spec = 1'b0;
    end
  end

  logic [6:1]         v_r;
  logic [5:1]         spec_r;
  logic [31:0]        sval1_r, sval2_r, sval3_r, sval4_r, sval5_r;
  logic [47:0]        prod1_r;
  logic signed [11:0] xe1_r, ye1_r;
  logic [23:0]        y1_r;
  logic               sp1_r, sc1_r, cz1_r;

  // stage 2 normalize to bit 61
  logic [5:0]         tx, ty, sx, sy;
  logic [63:0]        x2, y2;
  logic signed [11:0] xe2, ye2;
  logic [63:0]        x2_r, y2_r;
  logic signed [11:0] xe2_r, ye2_r;
  logic               sp2_r, sc2_r, cz2_r;

  assign tx  = fmm_pkg::top_bit64({16'd0, prod1_r});
  assign ty  = fmm_pkg::top_bit64({40'd0, y1_r});
  assign sx  = 6'd61 - tx;
  assign sy  = 6'd61 - ty;
  assign x2  = {16'd0, prod1_r} << sx;
  assign y2  = {40'd0, y1_r} << sy;
  assign xe2 = xe1_r - $signed({6'd0, sx});
  assign ye2 = ye1_r - $signed({6'd0, sy});

  // stage 3 align and add
  logic [63:0]        big, minor, minor_sh, r3;
  logic signed [11:0] be, se, d;
  logic               bs, ss, rs3, lost;
  logic [63:0]        r3_r;
  logic signed [11:0] be3_r;
  logic               rs3_r, zero3_r;

  always_comb begin
    if (xe2_r >= ye2_r) begin
      big = x2_r; be = xe2_r; bs = sp2_r; minor = y2_r; se = ye2_r; ss = sc2_r;
    end else begin
      big = y2_r; be = ye2_r; bs = sc2_r; minor = x2_r; se = xe2_r; ss = sp2_r;
    end
    d = be - se;
    lost = |(minor & ~({64{1'b1}} << d[5:0]));
    if (d > 12'sd62) begin
      minor_sh = 64'd1;
    end else begin
      minor_sh = (minor >> d[5:0]) | {63'd0, lost};
    end
    if (cz2_r) begin
      r3 = x2_r; rs3 = sp2_r;
    end else if (bs == ss) begin
      r3 = big + minor_sh; rs3 = bs;
    end else if (big >= minor_sh) begin
      r3 = big - minor_sh; rs3 = bs;
    end else begin
      r3 = minor_sh - big; rs3 = ss;
    end
  end

  // stage 4 exponent and shift amount
  logic [5:0]         p4;
  logic signed [11:0] e4, sh4;
  logic [63:0]        r4_r;
  logic signed [11:0] e4_r, sh4_r;
  logic               rs4_r, zero4_r;

  always_comb begin
    p4 = fmm_pkg::top_bit64(r3_r);
    e4 = $signed({6'd0, p4}) + be3_r + 12'sd127;
    if (e4 < 12'sd1) begin
      sh4 = -be3_r - 12'sd149;
      e4  = 12'sd1;
    end else begin
      sh4 = $signed({6'd0, p4}) - 12'sd23;
    end
  end

  // stage 5 shift and round
  logic [11:0]        nsh;
  logic [5:0]         ramt, gb;
  logic [63:0]        m64;
  logic               guard, sticky;
  logic [24:0]        m5;
  logic [24:0]        m5_r;
  logic signed [11:0] e5_r;
  logic               rs5_r, zero5_r;

  always_comb begin
    nsh    = 12'(-sh4_r);
    ramt   = sh4_r[5:0];
    gb     = ramt - 6'd1;
    m64    = r4_r >> ramt;
    guard  = r4_r[gb];
    sticky = |(r4_r & ~({64{1'b1}} << gb));
    if (sh4_r <= 12'sd0) begin
      m64 = r4_r << nsh[5:0];
      m5  = m64[24:0];
    end else if (sh4_r > 12'sd63) begin
      m5 = 25'd0;
    end else begin
      m5 = m64[24:0] + 25'(guard & (sticky | m64[0]));
    end
  end

  // stage 6 pack
  logic [23:0]        m6;
  logic signed [11:0] e6;
  logic [31:0]        packed6;
  logic [31:0]        result_r;

  always_comb begin
    if (m5_r[24]) begin
      m6 = m5_r[24:1];
      e6 = e5_r + 12'sd1;
    end else begin
      m6 = m5_r[23:0];
      e6 = e5_r;
    end
    if (e6 >= 12'sd255)  packed6 = {rs5_r, 8'hFF, 23'd0};
    else if (m6[23])     packed6 = {rs5_r, e6[7:0], m6[22:0]};
    else                 packed6 = {rs5_r, 8'd0, m6[22:0]};
    if (spec_r[5])       packed6 = sval5_r;
    else if (zero5_r)    packed6 = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:1], req.start};
    end
    spec_r  <= {spec_r[4:1], spec};
    sval1_r <= sval;
    sval2_r <= sval1_r;
    sval3_r <= sval2_r;
    sval4_r <= sval3_r;
    sval5_r <= sval4_r;
    prod1_r <= ma * mb;
    xe1_r   <= $signed({4'd0, eea}) + $signed({4'd0, eeb}) - 12'sd300;
    y1_r    <= mc;
    ye1_r   <= $signed({4'd0, eec}) - 12'sd150;
    sp1_r   <= sp;
    sc1_r   <= sc;
    cz1_r   <= cz;
    x2_r    <= x2;
    y2_r    <= y2;
    xe2_r   <= xe2;
    ye2_r   <= ye2;
    sp2_r   <= sp1_r;
    sc2_r   <= sc1_r;
    cz2_r   <= cz1_r;
    r3_r    <= r3;
    be3_r   <= cz2_r ? xe2_r : be;
    rs3_r   <= rs3;
    zero3_r <= (r3 == 64'd0);
    r4_r    <= r3_r;
    e4_r    <= e4;
    sh4_r   <= sh4;
    rs4_r   <= rs3_r;
    zero4_r <= zero3_r;
    m5_r    <= m5;
    e5_r    <= e4_r;
    rs5_r   <= rs4_r;
    zero5_r <= zero4_r;
    result_r <= packed6;
  end

  assign rsp = {v_r[6], result_r};

endmodule
`default_nettype wire

FILE: hdl/fmm_mats.sv
`default_nettype none
// left and right operand stores, one write and one registered read each
module fmm_mats #(
  parameter int MAX_ROWS  = fmm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = fmm_pkg::DEF_MAX_COLS,
  parameter int MAX_DEPTH = fmm_pkg::DEF_MAX_DEPTH,
  localparam int A_DEPTH  = MAX_ROWS * MAX_DEPTH,
  localparam int B_DEPTH  = MAX_DEPTH * MAX_COLS,
  localparam int AW       = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1,
  localparam int BW       = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          a_we,
  input  wire logic [AW-1:0] a_waddr,
  input  wire logic          b_we,
  input  wire logic [BW-1:0] b_waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] a_raddr,
  input  wire logic [BW-1:0] b_raddr,
  output logic [31:0]        a_rdata,
  output logic [31:0]        b_rdata
);

  logic [31:0] a_mem [A_DEPTH];
  logic [31:0] b_mem [B_DEPTH];

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= wdata;
    if (rd_en) a_rdata <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_waddr] <= wdata;
    if (rd_en) b_rdata <= b_mem[b_raddr];
  end

endmodule
`default_nettype wire

FILE: dv/fmm_checker.sv
`default_nettype none
module fmm_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire fmm_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire fmm_pkg::out_item_t out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  output int                      error_count,
  output int                      pending_count,
  output int                      results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] left_elems  [0:fmm_pkg::DEF_MAX_ROWS*fmm_pkg::DEF_MAX_DEPTH-1];
  logic [31:0] right_elems [0:fmm_pkg::DEF_MAX_DEPTH*fmm_pkg::DEF_MAX_COLS-1];
  logic [7:0]  rows_reg, cols_reg, depth_reg;
  fmm_pkg::out_item_t c_expected_q[$];
  int          errs = 0;
  int          checked = 0;

  function automatic int msb64(logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  // value = r * 2^re rounded to nearest even single, subnormals kept
  function automatic logic [31:0] round_single(logic sign, logic [63:0] r, int re);
    int p, e, sh;
    logic [63:0] m, rem, half;
    p = msb64(r);
    e = p + re + 127;
    if (e < 1) begin
      sh = -re - 149;
      e = 1;
    end else begin
      sh = p - 23;
    end
    if (sh <= 0) begin
      m = r << (-sh);
    end else if (sh > 63) begin
      m = '0;
    end else begin
      rem  = r & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      m = r >> sh;
      if (rem > half || (rem == half && m[0])) m = m + 64'd1;
    end
    if (m >= (64'd1 << 24)) begin
      m = m >> 1;
      e = e + 1;
    end
    if (e >= 255) return {sign, 8'hFF, 23'd0};
    if (m >= (64'd1 << 23)) return {sign, 8'(e), m[22:0]};
    return {sign, 8'd0, m[22:0]};
  endfunction

  // single rounding of a*b+c
  function automatic logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b,
                                                logic [31:0] c);
    logic sa, sb, sc, sp, bs, ss, rs;
    logic [7:0] ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic az, bz, cz;
    logic [63:0] x, y, major_m, minor_m, r, lost;
    int xe, ye, be, se, d, s;
    sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
    ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
    fa = a[22:0]; fb = b[22:0]; fc = c[22:0];
    az = (ea == 0 && fa == 0);
    bz = (eb == 0 && fb == 0);
    cz = (ec == 0 && fc == 0);
    if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0) || (ec == 8'hFF && fc != 0))
      return fmm_pkg::QNAN32;
    if (ea == 8'hFF || eb == 8'hFF) begin
      if (az || bz) return fmm_pkg::QNAN32;
      if (ec == 8'hFF && sc != sp) return fmm_pkg::QNAN32;
      return {sp, 8'hFF, 23'd0};
    end
    if (ec == 8'hFF) return c;
    if (az || bz) begin
      if (cz) return (sp == sc) ? {sp, 31'd0} : 32'd0;
      return c;
    end
    x = {40'd0, ea != 0, fa} * {40'd0, eb != 0, fb};
    xe = (ea != 0 ? int'(ea) : 1) + (eb != 0 ? int'(eb) : 1) - 300;
    s = 61 - msb64(x);
    x = x << s;
    xe = xe - s;
    if (cz) return round_single(sp, x, xe);
    y = {40'd0, ec != 0, fc};
    ye = (ec != 0 ? int'(ec) : 1) - 150;
    s = 61 - msb64(y);
    y = y << s;
    ye = ye - s;
    if (xe >= ye) begin
      major_m = x; be = xe; bs = sp; minor_m = y; se = ye; ss = sc;
    end else begin
      major_m = y; be = ye; bs = sc; minor_m = x; se = xe; ss = sp;
    end
    d = be - se;
    if (d > 62) begin
      minor_m = 64'd1;
    end else begin
      lost = minor_m & ((64'd1 << d) - 64'd1);
      minor_m = minor_m >> d;
      if (lost != 0) minor_m[0] = 1'b1;
    end
    if (bs == ss) begin
      r = major_m + minor_m;
      rs = bs;
    end else if (major_m >= minor_m) begin
      r = major_m - minor_m;
      rs = bs;
    end else begin
      r = minor_m - major_m;
      rs = ss;
    end
    if (r == 0) return 32'd0;
    return round_single(rs, r, be);
  endfunction

  function automatic int clamp_size(logic [7:0] v, int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // tiled dot product of one row of the left store and one column of the right
  function automatic logic [31:0] product_element(int row, int col, int nd);
    logic [31:0] acc, tile;
    int kend;
    acc = 32'd0;
    for (int k0 = 0; k0 < nd; k0 += fmm_pkg::DEF_DEPTH_TILE) begin
      tile = 32'd0;
      kend = (nd - k0 > fmm_pkg::DEF_DEPTH_TILE) ? k0 + fmm_pkg::DEF_DEPTH_TILE : nd;
      for (int k = k0; k < kend; k++)
        tile = fused_mul_add(left_elems[row*fmm_pkg::DEF_MAX_DEPTH + k],
                             right_elems[k*fmm_pkg::DEF_MAX_COLS + col], tile);
      acc = fused_mul_add(tile, fmm_pkg::ONE32, acc);
    end
    return acc;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    fmm_pkg::out_item_t want;
    int nr, nc, nd, row, col;
    if (!rst_n) begin
      rows_reg  = fmm_pkg::SIZE_RESET;
      cols_reg  = fmm_pkg::SIZE_RESET;
      depth_reg = fmm_pkg::SIZE_RESET;
      c_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (fmm_pkg::cfg_idx_t'(cfg_index))
          fmm_pkg::CFG_ROWS:  rows_reg  = cfg_data;
          fmm_pkg::CFG_COLS:  cols_reg  = cfg_data;
          fmm_pkg::CFG_DEPTH: depth_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        checked++;
        if (c_expected_q.size() == 0) begin
          $display("%0t unexpected result expected none actual %h", $time, out_data);
          errs++;
        end else begin
          want = c_expected_q.pop_front();
          check_field("c_value", want.c_value, out_data.c_value);
          check_field("out_row", 32'(want.out_row), 32'(out_data.out_row));
          check_field("out_col", 32'(want.out_col), 32'(out_data.out_col));
          check_field("range_error", 32'(want.range_error), 32'(out_data.range_error));
        end
      end
      if (in_valid && in_ready) begin
        nr  = clamp_size(rows_reg, fmm_pkg::DEF_MAX_ROWS);
        nc  = clamp_size(cols_reg, fmm_pkg::DEF_MAX_COLS);
        nd  = clamp_size(depth_reg, fmm_pkg::DEF_MAX_DEPTH);
        row = int'(in_data.row_index);
        col = int'(in_data.col_index);
        case (fmm_pkg::req_t'(in_data.req_type))
          fmm_pkg::REQ_WRITE_A:
            if (row < nr && col < nd)
              left_elems[row*fmm_pkg::DEF_MAX_DEPTH + col] = in_data.elem_value;
          fmm_pkg::REQ_WRITE_B:
            if (row < nd && col < nc)
              right_elems[row*fmm_pkg::DEF_MAX_COLS + col] = in_data.elem_value;
          fmm_pkg::REQ_COMPUTE: begin
            want.out_row = in_data.row_index;
            want.out_col = in_data.col_index;
            if (row >= nr || col >= nc) begin
              want.c_value = 32'd0;
              want.range_error = 1'b1;
            end else begin
              want.c_value = product_element(row, col, nd);
              want.range_error = 1'b0;
            end
            c_expected_q = {c_expected_q, want};
          end
          default: ;
        endcase
      end
    end
    error_count   <= errs;
    pending_count <= c_expected_q.size();
    results_seen  <= checked;
  end
endmodule
`default_nettype wire

FILE: dv/tb_float_matrix_multiply_unit.sv
`default_nettype none
module tb_float_matrix_multiply_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 20000;  // cycles with no beat on either channel
  localparam int LONG_HOLD   = 2000;   // one long receiver stall to back up the block
  localparam int SETTLE      = 20;     // wait after the last result before the sizes change

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  fmm_pkg::in_item_t  in_data   = '0;
  logic               in_ready;
  logic               out_valid;
  logic               out_ready = 1'b0;
  fmm_pkg::out_item_t out_data;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = fmm_pkg::CFG_ROWS;
  logic [7:0]         cfg_data  = '0;

  int error_count, pending_count, results_seen;

  // stimulus-side view of the sizes and of which store entries hold data
  int rows_eff = fmm_pkg::DEF_MAX_ROWS, cols_eff = fmm_pkg::DEF_MAX_COLS;
  int depth_eff = fmm_pkg::DEF_MAX_DEPTH;
  bit left_written  [0:fmm_pkg::DEF_MAX_ROWS-1][0:fmm_pkg::DEF_MAX_DEPTH-1];
  bit right_written [0:fmm_pkg::DEF_MAX_DEPTH-1][0:fmm_pkg::DEF_MAX_COLS-1];
  int beats_sent = 0;
  int phases_run = 0;
  bit send_calm = 0;
  bit recv_calm = 0;
  bit long_hold_done = 0;
  int idle_cycles = 0;

  float_matrix_multiply_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fmm_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending_count(pending_count),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a stuck handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("float_matrix_multiply_unit test failed");
        $finish;
      end
    end
  end

  // result side: random gaps, calm stretches, and one long hold-off
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_calm = ~recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 3);
      if (!long_hold_done && results_seen >= 30) begin
        gap = LONG_HOLD;
        long_hold_done = 1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // mix of ordinary, subnormal, special and fully random single bit patterns
  function automatic logic [31:0] pick_value();
    logic [31:0] specials [9] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                                  32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF};
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return specials[$urandom_range(0, 8)];
      3:       return {1'($urandom), 8'd0, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
    endcase
  endfunction

  // one input beat with a random lead-in gap; tracks which entries hold data
  task automatic send_beat(fmm_pkg::req_t req, int row, int col, logic [31:0] val);
    int gap;
    fmm_pkg::in_item_t beat;
    if ($urandom_range(0, 31) == 0) send_calm = ~send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    beat.req_type   = req;
    beat.row_index  = 7'(row);
    beat.col_index  = 7'(col);
    beat.elem_value = val;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!(in_valid && in_ready));
    beats_sent++;
    if (req == fmm_pkg::REQ_WRITE_A && row < rows_eff && col < depth_eff)
      left_written[row][col] = 1;
    if (req == fmm_pkg::REQ_WRITE_B && row < depth_eff && col < cols_eff)
      right_written[row][col] = 1;
  endtask

  // sizes change only with nothing in flight
  task automatic set_sizes(int rows, int cols, int depth);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= fmm_pkg::CFG_ROWS; cfg_data <= 8'(rows); @(posedge clk);
    cfg_index <= fmm_pkg::CFG_COLS;  cfg_data <= 8'(cols);  @(posedge clk);
    cfg_index <= fmm_pkg::CFG_DEPTH; cfg_data <= 8'(depth); @(posedge clk);
    cfg_we <= 1'b0;
    rows_eff  = (rows  > fmm_pkg::DEF_MAX_ROWS)  ? fmm_pkg::DEF_MAX_ROWS  : rows;
    cols_eff  = (cols  > fmm_pkg::DEF_MAX_COLS)  ? fmm_pkg::DEF_MAX_COLS  : cols;
    depth_eff = (depth > fmm_pkg::DEF_MAX_DEPTH) ? fmm_pkg::DEF_MAX_DEPTH : depth;
    phases_run++;
  endtask

  // load whatever the dot product still lacks, then ask for the element
  task automatic compute_element(int row, int col, ref int count);
    if (row < rows_eff && col < cols_eff) begin
      for (int k = 0; k < depth_eff; k++) begin
        if (!left_written[row][k]) begin
          send_beat(fmm_pkg::REQ_WRITE_A, row, k, pick_value());
          count++;
        end
        if (!right_written[k][col]) begin
          send_beat(fmm_pkg::REQ_WRITE_B, k, col, pick_value());
          count++;
        end
      end
    end
    send_beat(fmm_pkg::REQ_COMPUTE, row, col, $urandom);
    count++;
  endtask

  task automatic random_phase(int budget);
    int count, pick, row, col;
    count = 0;
    while (count < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 25 && rows_eff > 0 && depth_eff > 0) begin
        send_beat(fmm_pkg::REQ_WRITE_A, $urandom_range(0, rows_eff-1),
                  $urandom_range(0, depth_eff-1), pick_value());
        count++;
      end else if (pick < 50 && depth_eff > 0 && cols_eff > 0) begin
        send_beat(fmm_pkg::REQ_WRITE_B, $urandom_range(0, depth_eff-1),
                  $urandom_range(0, cols_eff-1), pick_value());
        count++;
      end else if (pick < 60) begin
        // any index, out-of-range ones get dropped
        send_beat($urandom_range(0, 1) ? fmm_pkg::REQ_WRITE_B : fmm_pkg::REQ_WRITE_A,
                  $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
        count++;
      end else if (pick < 64) begin
        send_beat(fmm_pkg::REQ_NONE, $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom);
      end else begin
        if (rows_eff > 0 && cols_eff > 0 && $urandom_range(0, 4) != 0) begin
          row = $urandom_range(0, rows_eff-1);
          col = $urandom_range(0, cols_eff-1);
        end else begin
          row = $urandom_range(0, 127);
          col = $urandom_range(0, 127);
        end
        compute_element(row, col, count);
      end
    end
  endtask

  initial begin
    int plan [10][4] = '{'{1, 1, 1, 100}, '{2, 3, 64, 150}, '{5, 4, 65, 150},
                         '{8, 8, 7, 200}, '{3, 2, 0, 60}, '{0, 5, 5, 60},
                         '{6, 1, 128, 250}, '{255, 200, 130, 250},
                         '{16, 16, 16, 250}, '{7, 9, 63, 150}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small sizes, special operands, range cases
    set_sizes(4, 4, 3);
    send_beat(fmm_pkg::REQ_WRITE_A, 0, 0, 32'h3F80_0000);
    send_beat(fmm_pkg::REQ_WRITE_A, 0, 1, 32'h7F7F_FFFF);
    send_beat(fmm_pkg::REQ_WRITE_A, 0, 2, 32'h0000_0001);
    send_beat(fmm_pkg::REQ_WRITE_B, 0, 0, 32'h4000_0000);
    send_beat(fmm_pkg::REQ_WRITE_B, 1, 0, 32'h7F7F_FFFF);  // overflow inside the tile
    send_beat(fmm_pkg::REQ_WRITE_B, 2, 0, 32'h8000_0001);
    send_beat(fmm_pkg::REQ_COMPUTE, 0, 0, 32'hFFFF_FFFF);
    send_beat(fmm_pkg::REQ_WRITE_B, 1, 0, 32'hBF80_0000);  // rewrite, no overflow now
    send_beat(fmm_pkg::REQ_COMPUTE, 0, 0, 32'h0000_0000);
    send_beat(fmm_pkg::REQ_WRITE_A, 1, 0, 32'h7F80_0000);
    send_beat(fmm_pkg::REQ_WRITE_A, 1, 1, 32'h0000_0000);
    send_beat(fmm_pkg::REQ_WRITE_A, 1, 2, 32'hFFFF_FFFF);  // nan operand
    send_beat(fmm_pkg::REQ_COMPUTE, 1, 0, 32'h0);
    send_beat(fmm_pkg::REQ_WRITE_A, 2, 0, 32'h7F80_0000);
    send_beat(fmm_pkg::REQ_WRITE_A, 2, 1, 32'hFF80_0000);  // minus inf times minus one, so inf plus inf
    send_beat(fmm_pkg::REQ_WRITE_A, 2, 2, 32'h0000_0000);
    send_beat(fmm_pkg::REQ_COMPUTE, 2, 0, 32'h0);
    send_beat(fmm_pkg::REQ_COMPUTE, 127, 0, 32'h0);        // row out of range
    send_beat(fmm_pkg::REQ_COMPUTE, 0, 127, 32'h0);        // column out of range
    send_beat(fmm_pkg::REQ_WRITE_A, 127, 127, 32'hFFFF_FFFF);  // dropped write
    send_beat(fmm_pkg::REQ_WRITE_B, 3, 0, 32'h3F80_0000);      // depth row out of range
    send_beat(fmm_pkg::REQ_NONE, 127, 127, 32'hFFFF_FFFF);     // unused request code

    // random phases over several size settings, zero and clamped sizes included
    foreach (plan[i]) begin
      set_sizes(plan[i][0], plan[i][1], plan[i][2]);
      random_phase(plan[i][3]);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("summary: %0d input beats over %0d size settings, %0d results checked",
             beats_sent, phases_run, results_seen);
    $display("summary: special operands, range errors, dropped writes, zero depth, full depth");
    if (error_count == 0 && pending_count == 0) begin
      $display("float_matrix_multiply_unit test passed");
    end else begin
      $display("float_matrix_multiply_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: float_matrix_multiply_unit.f
+incdir+hdl
hdl/fmm_pkg.sv
hdl/fmm_fma.sv
hdl/fmm_mats.sv
hdl/float_matrix_multiply_unit.sv
dv/fmm_checker.sv
dv/tb_float_matrix_multiply_unit.sv
